FILE: hdl/dmcr_pkg.sv
package dmcr_pkg;

  localparam int PIX_W        = 17;
  localparam int COLOUR_W     = 24;
  localparam int DASH_W       = 8;
  localparam int PIX_PER_STEP = 8;
  localparam int IDX_W        = 3;

  localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(PIX_PER_STEP - 1);
  localparam logic [DASH_W-1:0] DASH_RESET = DASH_W'(1);

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } opcode_t;

endpackage

FILE: hdl/dmcr_ifs.sv
interface dmcr_cmd_if
  import dmcr_pkg::*;
#(
  parameter int COORD_BITS  = 16,
  parameter int RADIUS_BITS = 12
) ();
  logic                          valid;
  logic                          ready;
  opcode_t                       opcode;
  logic signed [COORD_BITS-1:0]  centre_x;
  logic signed [COORD_BITS-1:0]  centre_y;
  logic        [RADIUS_BITS-1:0] radius;
  logic        [COLOUR_W-1:0]    colour;
  logic                          dashed;

  modport source (
    output valid, opcode, centre_x, centre_y, radius, colour, dashed,
    input  ready
  );
  modport sink (
    input  valid, opcode, centre_x, centre_y, radius, colour, dashed,
    output ready
  );
endinterface

interface dmcr_pix_if
  import dmcr_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [PIX_W-1:0]  pixel_x;
  logic signed [PIX_W-1:0]  pixel_y;
  logic        [COLOUR_W-1:0] pixel_colour;
  logic                     pixel_on;
  logic                     last_of_step;
  logic                     circle_done;

  modport source (
    output valid, pixel_x, pixel_y, pixel_colour, pixel_on, last_of_step, circle_done,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_colour, pixel_on, last_of_step, circle_done,
    output ready
  );
endinterface

FILE: hdl/dashed_midpoint_circle_rasterizer_core.sv
// Midpoint circle rasterizer with an optional dash pattern.
// Items arrive on the cmd channel (valid/ready). A start item loads the centre,
// radius, colour and dash flag and produces no pixels. A step item, while a
// circle is in progress, produces eight octant-mirrored pixels on the pix
// channel, one per cycle; the eighth carries last_of_step, and on the final
// step of the circle also circle_done. A step with no circle in progress is
// consumed silently. cfg_we/cfg_wdata write dash_length, the number of steps
// per dash segment, and should only be written while the block is idle.
// The step register captures an accepted step item, and the output register then
// takes its first pixel. Throughput: one pixel per cycle while the receiver takes
// them, paced by the eight-entry pixel sequencer behind the step register.
// A new item is accepted in the cycle the eighth pixel of the previous step
// leaves the step register, so items can follow each other without gaps.
// When the receiver stalls, the output register holds its pixel and the step
// register waits; cmd.ready falls until the step has drained.
// Reset (rst, synchronous) clears the circle in progress, empties both
// registers and returns dash_length to one.
module dashed_midpoint_circle_rasterizer_core
  import dmcr_pkg::*;
#(
  parameter int RADIUS_BITS = 12,
  parameter int COORD_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [DASH_W-1:0] cfg_wdata,
  dmcr_cmd_if.sink          cmd,
  dmcr_pix_if.source        pix
);

  localparam int X_W   = RADIUS_BITS;
  localparam int Y_W   = RADIUS_BITS + 1;
  localparam int E_W   = RADIUS_BITS + 3;
  localparam int S_W   = RADIUS_BITS + 4;
  localparam int C_MAX = (COORD_BITS > Y_W + 1) ? COORD_BITS : Y_W + 1;
  localparam int SUM_W = (C_MAX + 1 > PIX_W) ? C_MAX + 1 : PIX_W;

  localparam logic signed [S_W-1:0] ONE_S = S_W'(1);

  // Circle state
  logic [DASH_W-1:0]            dash_length;
  logic signed [COORD_BITS-1:0] held_centre_x;
  logic signed [COORD_BITS-1:0] held_centre_y;
  logic [X_W-1:0]               x_offset;
  logic [Y_W-1:0]               y_offset;
  logic signed [E_W-1:0]        error_term;
  logic [COLOUR_W-1:0]          held_colour;
  logic                         dash_enable;
  logic                         dash_on;
  logic [DASH_W-1:0]            dash_count;
  logic                         active;

  // Step register: snapshot of one step, drained one pixel per cycle while the output register can load
  logic                         step_valid;
  logic [IDX_W-1:0]             step_idx;
  logic signed [COORD_BITS-1:0] step_cx;
  logic signed [COORD_BITS-1:0] step_cy;
  logic [X_W-1:0]               step_x;
  logic [Y_W-1:0]               step_y;
  logic [COLOUR_W-1:0]          step_colour;
  logic                         step_on;
  logic                         step_done;

  logic out_load;
  logic step_drain;
  logic accept;
  logic step_go;

  assign out_load   = !pix.valid || pix.ready;
  assign step_drain = step_valid && out_load && (step_idx == LAST_IDX);
  assign cmd.ready  = !step_valid || step_drain;
  assign accept     = cmd.valid && cmd.ready;
  assign step_go    = accept && (cmd.opcode == OP_STEP) && active;

  // Midpoint update
  logic signed [S_W-1:0]  err_a;
  logic signed [S_W-1:0]  err_b;
  logic signed [S_W-1:0]  x_ext;
  logic signed [S_W-1:0]  x_dec;
  logic signed [S_W-1:0]  x_new;
  logic signed [S_W-1:0]  y_new;
  logic                   x_moves;
  logic                   done_next;
  logic [DASH_W-1:0]      cnt_inc;

  always_comb begin
    x_ext     = $signed({{(S_W-X_W){1'b0}}, x_offset});
    err_a     = $signed({{(S_W-E_W){error_term[E_W-1]}}, error_term})
              + $signed({{(S_W-Y_W-1){1'b0}}, y_offset, 1'b1});
    x_dec     = x_ext - ONE_S;
    x_moves   = !err_a[S_W-1];
    err_b     = x_moves ? (err_a - (x_dec <<< 1)) : err_a;
    x_new     = x_moves ? x_dec : x_ext;
    y_new     = $signed({{(S_W-Y_W){1'b0}}, y_offset}) + ONE_S;
    done_next = y_new > x_new;
    cnt_inc   = dash_count + DASH_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dash_length <= DASH_RESET;
      active      <= 1'b0;
      dash_enable <= 1'b0;
      dash_on     <= 1'b1;
      dash_count  <= '0;
    end else begin
      if (cfg_we) begin
        dash_length <= cfg_wdata;
      end
      if (accept && cmd.opcode == OP_START) begin
        held_centre_x <= cmd.centre_x;
        held_centre_y <= cmd.centre_y;
        x_offset      <= X_W'(cmd.radius);
        y_offset      <= '0;
        error_term    <= -$signed({{(E_W-RADIUS_BITS){1'b0}}, cmd.radius});
        held_colour   <= cmd.colour;
        dash_enable   <= cmd.dashed;
        dash_on       <= 1'b1;
        dash_count    <= '0;
        active        <= 1'b1;
      end else if (step_go) begin
        x_offset   <= x_new[X_W-1:0];
        y_offset   <= y_new[Y_W-1:0];
        error_term <= err_b[E_W-1:0];
        if (dash_enable) begin
          if (cnt_inc == dash_length) begin
            dash_count <= '0;
            dash_on    <= !dash_on;
          end else begin
            dash_count <= cnt_inc;
          end
        end
        if (done_next) begin
          active <= 1'b0;
        end
      end
    end
  end

  // Octant mirroring: the index picks which offset feeds each axis and its sign.
  logic                    use_y;
  logic [Y_W-1:0]          mag_a;
  logic [Y_W-1:0]          mag_b;
  logic signed [SUM_W-1:0] cx_ext;
  logic signed [SUM_W-1:0] cy_ext;
  logic signed [SUM_W-1:0] a_ext;
  logic signed [SUM_W-1:0] b_ext;
  logic signed [SUM_W-1:0] px_sum;
  logic signed [SUM_W-1:0] py_sum;

  always_comb begin
    use_y  = step_idx[2] ^ step_idx[1];
    mag_a  = use_y ? step_y : {1'b0, step_x};
    mag_b  = use_y ? {1'b0, step_x} : step_y;
    cx_ext = $signed({{(SUM_W-COORD_BITS){step_cx[COORD_BITS-1]}}, step_cx});
    cy_ext = $signed({{(SUM_W-COORD_BITS){step_cy[COORD_BITS-1]}}, step_cy});
    a_ext  = $signed({{(SUM_W-Y_W){1'b0}}, mag_a});
    b_ext  = $signed({{(SUM_W-Y_W){1'b0}}, mag_b});
    px_sum = step_idx[2] ? (cx_ext - a_ext) : (cx_ext + a_ext);
    py_sum = step_idx[0] ? (cy_ext - b_ext) : (cy_ext + b_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_valid <= 1'b0;
      step_idx   <= '0;
      pix.valid  <= 1'b0;
    end else begin
      if (out_load) begin
        pix.valid <= step_valid;
        if (step_valid) begin
          pix.pixel_x      <= px_sum[PIX_W-1:0];
          pix.pixel_y      <= py_sum[PIX_W-1:0];
          pix.pixel_colour <= step_colour;
          pix.pixel_on     <= step_on;
          pix.last_of_step <= (step_idx == LAST_IDX);
          pix.circle_done  <= (step_idx == LAST_IDX) && step_done;
        end
      end
      if (step_go) begin
        step_valid  <= 1'b1;
        step_idx    <= '0;
        step_cx     <= held_centre_x;
        step_cy     <= held_centre_y;
        step_x      <= x_offset;
        step_y      <= y_offset;
        step_colour <= held_colour;
        step_on     <= dash_on;
        step_done   <= done_next;
      end else begin
        if (out_load && step_valid) begin
          step_idx <= step_idx + IDX_W'(1);
        end
        if (step_drain) begin
          step_valid <= 1'b0;
        end
      end
    end
  end

  // The done flag only ever accompanies the closing pixel of a step.
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    pix.valid && pix.circle_done |-> pix.last_of_step)
    else $error("circle_done without last_of_step");

  // Once the final step is captured, no circle remains in progress.
  a_done_clears_active: assert property (@(posedge clk) disable iff (rst)
    step_valid && step_done |-> !active)
    else $error("circle still active after its final step");

  // The midpoint walk stops before y overtakes x.
  a_offsets_ordered: assert property (@(posedge clk) disable iff (rst)
    active |-> ({1'b0, x_offset} >= y_offset))
    else $error("y_offset passed x_offset on an active circle");

  // A step item that starts a new snapshot restarts the pixel sequence.
  a_step_restarts: assert property (@(posedge clk) disable iff (rst)
    step_go |=> step_valid && (step_idx == '0))
    else $error("step register did not restart on a new step");

endmodule
